[rtl/equirect_env_map_bilinear_lookup_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion helpers for the environment map lookup
// Shared property forms, sampled on clock and held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef EQUIRECT_ENV_MAP_BILINEAR_LOOKUP_TOP_ASSERT_SVH
`define EQUIRECT_ENV_MAP_BILINEAR_LOOKUP_TOP_ASSERT_SVH

// when ante holds, cons must hold in the same cycle
`define EQRMAP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cond must never hold
`define EQRMAP_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`endif

[rtl/eqrmap_pkg.sv]
// ----------------------------------------------------------------------------
// eqrmap_pkg
// Types, constants and the arctangent table of the environment map lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eqrmap_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = 5;
   localparam int FRAC_BITS    = 8;
   localparam int ADDR_W       = 17;
   localparam int MAX_TEXELS   = 1 << ADDR_W;
   localparam int IDX_W        = 20;
   localparam int BASE_W       = 19;
   localparam int VEC_W        = 40;
   localparam int ANG_W        = 32;
   localparam int WIDTH_W      = 10;
   localparam int HEIGHT_W     = 9;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 10;
   localparam int TEXEL_W      = 24;
   localparam int COLOUR_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 1'b1;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [16:0]      GAIN_Q16     = 17'd107922;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 10'd512;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 9'd256;

   typedef struct packed {
      logic                      valid;
      logic                      func;
      logic [ADDR_W-1:0]         widx;
      logic [TEXEL_W-1:0]        wdata;
   } carry_type;

   typedef struct packed {
      carry_type                 tag;
      logic                      zero;
      logic                      zpos;
      logic                      zneg;
      logic signed [VEC_W-1:0]   a;
      logic signed [VEC_W-1:0]   b;
      logic signed [VEC_W-1:0]   zb;
      logic [ANG_W-1:0]          ang;
      logic [ANG_W-1:0]          lon;
   } lane_type;

   typedef struct packed {
      carry_type                 tag;
      logic [BASE_W-1:0]         base0;
      logic [BASE_W-1:0]         base1;
      logic [WIDTH_W-1:0]        col;
      logic [WIDTH_W-1:0]        col1;
      logic [FRAC_BITS-1:0]      sx;
      logic [FRAC_BITS-1:0]      sy;
   } fetch_type;

   function automatic logic [ANG_W-1:0] atan_lut(input logic [STEP_W-1:0] s);
      logic [ANG_W-1:0] r;
      case (s)
         5'd0:    r = 32'd536870912;
         5'd1:    r = 32'd316933406;
         5'd2:    r = 32'd167458907;
         5'd3:    r = 32'd85004756;
         5'd4:    r = 32'd42667331;
         5'd5:    r = 32'd21354465;
         5'd6:    r = 32'd10679838;
         5'd7:    r = 32'd5340245;
         5'd8:    r = 32'd2670163;
         5'd9:    r = 32'd1335087;
         5'd10:   r = 32'd667544;
         5'd11:   r = 32'd333772;
         5'd12:   r = 32'd166886;
         5'd13:   r = 32'd83443;
         5'd14:   r = 32'd41722;
         5'd15:   r = 32'd20861;
         5'd16:   r = 32'd10430;
         5'd17:   r = 32'd5215;
         5'd18:   r = 32'd2608;
         5'd19:   r = 32'd1304;
         5'd20:   r = 32'd652;
         5'd21:   r = 32'd326;
         5'd22:   r = 32'd163;
         5'd23:   r = 32'd81;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/eqrmap_cell.sv]
// ----------------------------------------------------------------------------
// eqrmap_cell
// One vectoring CORDIC micro-rotation, registered; hands its lane onward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "equirect_env_map_bilinear_lookup_top_assert.svh"

module eqrmap_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [eqrmap_pkg::STEP_W-1:0]     step,
   input  logic                              load_lat,
   input  eqrmap_pkg::lane_type              up_lane,
   output eqrmap_pkg::lane_type              dn_lane
);
   import eqrmap_pkg::*;

   lane_type                stage_ff;
   lane_type                stage_in;
   logic signed [VEC_W-1:0] a_e;
   logic signed [VEC_W-1:0] b_e;
   logic signed [VEC_W-1:0] da;
   logic signed [VEC_W-1:0] db;
   logic [ANG_W-1:0]        ang_e;

   always_comb begin
      stage_in = up_lane;
      a_e      = up_lane.a;
      // first latitude cell: keep the magnitude, swap in the scaled z, bank longitude
      b_e      = load_lat ? up_lane.zb : up_lane.b;
      ang_e    = load_lat ? '0 : up_lane.ang;
      if (load_lat) begin
         stage_in.lon = up_lane.ang + HALF_TURN;
      end
      da = b_e >>> step;
      db = a_e >>> step;
      if (!b_e[VEC_W-1]) begin
         stage_in.a   = a_e + da;
         stage_in.b   = b_e - db;
         stage_in.ang = ang_e + atan_lut(step);
      end else begin
         stage_in.a   = a_e - da;
         stage_in.b   = b_e + db;
         stage_in.ang = ang_e - atan_lut(step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.tag.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign dn_lane = stage_ff;

   `EQRMAP_ASSERT_NEVER(cell_mag_nonneg, dn_lane.tag.valid && dn_lane.a[VEC_W-1], "magnitude went negative")

endmodule

`default_nettype wire

[rtl/eqrmap_coord.sv]
// ----------------------------------------------------------------------------
// eqrmap_coord
// Angles to texel column, row, weights and row base addresses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eqrmap_coord (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [eqrmap_pkg::WIDTH_W-1:0]    map_width,
   input  logic [eqrmap_pkg::HEIGHT_W-1:0]   map_height,
   input  eqrmap_pkg::lane_type              up_lane,
   output eqrmap_pkg::fetch_type             fetch
);
   import eqrmap_pkg::*;

   // angle stage
   carry_type               c1_ff;
   logic [ANG_W-1:0]        u_ff;
   logic [ANG_W-1:0]        v_ff;
   logic [ANG_W-1:0]        u_in;
   logic [ANG_W-1:0]        v_in;
   logic signed [ANG_W+1:0] psi;
   logic signed [ANG_W+1:0] vfull;

   // scale stage
   carry_type               c2_ff;
   logic [ANG_W+WIDTH_W-1:0]  prod_x;
   logic [ANG_W+HEIGHT_W-1:0] prod_y;
   logic [WIDTH_W-1:0]      col2_ff;
   logic [HEIGHT_W-1:0]     rowr2_ff;
   logic [FRAC_BITS-1:0]    sx2_ff;
   logic [FRAC_BITS-1:0]    sy2_ff;

   // wrap stage
   carry_type               c3_ff;
   logic [WIDTH_W-1:0]      col3_ff;
   logic [WIDTH_W-1:0]      col13_ff;
   logic [HEIGHT_W-1:0]     row3_ff;
   logic [HEIGHT_W-1:0]     row13_ff;
   logic [FRAC_BITS-1:0]    sx3_ff;
   logic [FRAC_BITS-1:0]    sy3_ff;
   logic [HEIGHT_W-1:0]     row_in;
   logic [HEIGHT_W:0]       row_inc;
   logic [WIDTH_W:0]        col_inc;

   fetch_type               fetch_ff;

   always_comb begin
      if (up_lane.zero) begin
         u_in = HALF_TURN;
         if (up_lane.zpos) begin
            psi = $signed({2'b00, QUARTER_TURN});
         end else if (up_lane.zneg) begin
            psi = -$signed({2'b00, QUARTER_TURN});
         end else begin
            psi = '0;
         end
      end else begin
         u_in = up_lane.lon;
         psi  = (ANG_W+2)'($signed(up_lane.ang));
      end
      vfull = $signed({2'b00, QUARTER_TURN}) - psi;
      // clamp past the poles
      if (vfull[ANG_W+1]) begin
         v_in = '0;
      end else if (vfull > $signed({2'b00, HALF_TURN})) begin
         v_in = HALF_TURN;
      end else begin
         v_in = vfull[ANG_W-1:0];
      end
   end

   assign prod_x = u_ff * map_width;
   assign prod_y = v_ff * map_height;

   always_comb begin
      row_in  = (rowr2_ff == map_height) ? '0 : rowr2_ff;
      row_inc = {1'b0, row_in} + 1'b1;
      col_inc = {1'b0, col2_ff} + 1'b1;
   end

   always_ff @(posedge clock) begin
      u_ff     <= u_in;
      v_ff     <= v_in;

      col2_ff  <= prod_x[ANG_W +: WIDTH_W];
      sx2_ff   <= prod_x[ANG_W-1 -: FRAC_BITS];
      rowr2_ff <= prod_y[ANG_W-1 +: HEIGHT_W];
      sy2_ff   <= prod_y[ANG_W-2 -: FRAC_BITS];

      col3_ff  <= col2_ff;
      col13_ff <= (col_inc == {1'b0, map_width}) ? '0 : col_inc[WIDTH_W-1:0];
      row3_ff  <= row_in;
      row13_ff <= (row_inc == {1'b0, map_height}) ? '0 : row_inc[HEIGHT_W-1:0];
      sx3_ff   <= sx2_ff;
      sy3_ff   <= sy2_ff;

      fetch_ff.base0 <= row3_ff * map_width;
      fetch_ff.base1 <= row13_ff * map_width;
      fetch_ff.col   <= col3_ff;
      fetch_ff.col1  <= col13_ff;
      fetch_ff.sx    <= sx3_ff;
      fetch_ff.sy    <= sy3_ff;

      if (reset) begin
         c1_ff.valid        <= 1'b0;
         c2_ff.valid        <= 1'b0;
         c3_ff.valid        <= 1'b0;
         fetch_ff.tag.valid <= 1'b0;
      end else begin
         c1_ff        <= up_lane.tag;
         c2_ff        <= c1_ff;
         c3_ff        <= c2_ff;
         fetch_ff.tag <= c3_ff;
      end
   end

   assign fetch = fetch_ff;

endmodule

`default_nettype wire

[rtl/eqrmap_sample.sv]
// ----------------------------------------------------------------------------
// eqrmap_sample
// Texel store in four read copies, neighbour fetch and bilinear blend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "equirect_env_map_bilinear_lookup_top_assert.svh"

module eqrmap_sample (
   input  logic                              clock,
   input  logic                              reset,
   input  eqrmap_pkg::fetch_type             fetch,
   output logic                              rsp_valid,
   output logic [eqrmap_pkg::COLOUR_W-1:0]   rsp_red_out,
   output logic [eqrmap_pkg::COLOUR_W-1:0]   rsp_green_out,
   output logic [eqrmap_pkg::COLOUR_W-1:0]   rsp_blue_out
);
   import eqrmap_pkg::*;

   localparam int NB   = 4;
   localparam int P0_W = 2 * 8 + 1;
   localparam int P_W  = P0_W + FRAC_BITS + 1;
   localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

   logic [IDX_W-1:0]      addr [NB];
   logic [TEXEL_W-1:0]    texel [NB];
   logic [NB-1:0]         oob5_ff;
   logic                  v5_ff;
   logic [FRAC_BITS-1:0]  sx5_ff;
   logic [FRAC_BITS-1:0]  sy5_ff;
   logic                  wr_en;

   logic [P0_W-1:0]       p0_in [3];
   logic [P0_W-1:0]       p1_in [3];
   logic [P0_W-1:0]       p0_ff [3];
   logic [P0_W-1:0]       p1_ff [3];
   logic                  v6_ff;
   logic [FRAC_BITS-1:0]  sx6_ff;
   logic [FRAC_BITS:0]    wy0;
   logic [FRAC_BITS:0]    wx0;

   logic [P_W-1:0]        p_in [3];
   logic                  rsp_valid_ff;
   logic [COLOUR_W-1:0]   colour_ff [3];

   // neighbours: 0 row/col, 1 next row, 2 next col, 3 both
   always_comb begin
      addr[0] = IDX_W'(fetch.base0) + IDX_W'(fetch.col);
      addr[1] = IDX_W'(fetch.base1) + IDX_W'(fetch.col);
      addr[2] = IDX_W'(fetch.base0) + IDX_W'(fetch.col1);
      addr[3] = IDX_W'(fetch.base1) + IDX_W'(fetch.col1);
   end

   assign wr_en = fetch.tag.valid && (fetch.tag.func == FUNC_WRITE);

   for (genvar k = 0; k < NB; k++) begin : g_bank
      logic [TEXEL_W-1:0] mem [MAX_TEXELS];
      logic [TEXEL_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[fetch.tag.widx] <= fetch.tag.wdata;
         end
         rd_ff <= mem[addr[k][ADDR_W-1:0]];
      end

      // texels past the end of the store read as black
      assign texel[k] = oob5_ff[k] ? '0 : rd_ff;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NB; k++) begin
         oob5_ff[k] <= (addr[k][IDX_W-1:ADDR_W] != '0);
      end
      sx5_ff <= fetch.sx;
      sy5_ff <= fetch.sy;
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= fetch.tag.valid && (fetch.tag.func == FUNC_LOOKUP);
      end
   end

   // blend down the rows first
   always_comb begin
      wy0 = ONE - {1'b0, sy5_ff};
      for (int ch = 0; ch < 3; ch++) begin
         p0_in[ch] = P0_W'(texel[0][TEXEL_W-1-8*ch -: 8] * wy0)
                   + P0_W'(texel[1][TEXEL_W-1-8*ch -: 8] * sy5_ff);
         p1_in[ch] = P0_W'(texel[2][TEXEL_W-1-8*ch -: 8] * wy0)
                   + P0_W'(texel[3][TEXEL_W-1-8*ch -: 8] * sy5_ff);
      end
   end

   always_ff @(posedge clock) begin
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      sx6_ff <= sx5_ff;
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
   end

   // then across the columns, round half up
   always_comb begin
      wx0 = ONE - {1'b0, sx6_ff};
      for (int ch = 0; ch < 3; ch++) begin
         p_in[ch] = P_W'(p0_ff[ch] * wx0) + P_W'(p1_ff[ch] * sx6_ff)
                  + P_W'(1 << (FRAC_BITS - 1));
      end
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         colour_ff[ch] <= p_in[ch][FRAC_BITS +: COLOUR_W];
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= v6_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = colour_ff[0];
   assign rsp_green_out = colour_ff[1];
   assign rsp_blue_out  = colour_ff[2];

   `EQRMAP_ASSERT_IMPLY(smp_colour_range, rsp_valid, (rsp_red_out <= 16'hFF00) && (rsp_green_out <= 16'hFF00) && (rsp_blue_out <= 16'hFF00), "blended colour above full scale")

endmodule

`default_nettype wire

[rtl/equirect_env_map_bilinear_lookup_top.sv]
// ----------------------------------------------------------------------------
// equirect_env_map_bilinear_lookup_top
// Equirectangular environment map: texel store plus bilinear direction lookup.
// ----------------------------------------------------------------------------
// Use: raise start with req_func = 0 to store one RGB texel at req_texel_index,
// or with req_func = 1 to look up the direction req_dir_x/y/z (any scale).
// A beat is taken at every clock edge where start is high and busy is low;
// busy is high only during reset, so one beat per cycle is sustained.
// A lookup returns one colour on rsp_red/green/blue_out with rsp_valid high
// for one cycle. Writes return nothing and land in order with lookups. The
// pipeline is an entry stage, the chain of 32 CORDIC cells (16 for longitude,
// 16 for latitude), four coordinate stages and three fetch and blend stages.
// The receiver cannot hold results off; nothing is ever stalled.
// csr_we with csr_index writes map_width (0) or map_height (1); write only
// while no beat is in flight. Reset sets the map to 512 x 256 and drops all
// beats in flight; the texel store is not cleared and must be written first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "equirect_env_map_bilinear_lookup_top_assert.svh"

module equirect_env_map_bilinear_lookup_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_func,
   input  logic [eqrmap_pkg::ADDR_W-1:0]        req_texel_index,
   input  logic [7:0]                           req_red_in,
   input  logic [7:0]                           req_green_in,
   input  logic [7:0]                           req_blue_in,
   input  logic signed [15:0]                   req_dir_x,
   input  logic signed [15:0]                   req_dir_y,
   input  logic signed [15:0]                   req_dir_z,
   output logic                                 rsp_valid,
   output logic [eqrmap_pkg::COLOUR_W-1:0]      rsp_red_out,
   output logic [eqrmap_pkg::COLOUR_W-1:0]      rsp_green_out,
   output logic [eqrmap_pkg::COLOUR_W-1:0]      rsp_blue_out,
   input  logic                                 csr_we,
   input  logic [eqrmap_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [eqrmap_pkg::CSR_DATA_W-1:0]    csr_data
);
   import eqrmap_pkg::*;

   localparam int RSP_DELAY = 40;
   localparam int NCELL     = 2 * CORDIC_STEPS;

   logic [WIDTH_W-1:0]      width_ff;
   logic [HEIGHT_W-1:0]     height_ff;
   logic [WIDTH_W-1:0]      width_eff;
   logic [HEIGHT_W-1:0]     height_eff;

   lane_type                lane0_ff;
   lane_type                lane0_in;
   lane_type                chain [NCELL+1];
   fetch_type               fetch;

   logic signed [VEC_W-1:0] xe;
   logic signed [VEC_W-1:0] ye;
   logic signed [33:0]      zprod;
   logic                    accept;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  width_ff  <= csr_data[WIDTH_W-1:0];
            CSR_MAP_HEIGHT: height_ff <= csr_data[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign width_eff  = (width_ff == '0) ? WIDTH_W'(1) : width_ff;
   assign height_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;

   // entry stage: scale up, fold the left half-plane, prescale z by the gain
   always_comb begin
      xe    = VEC_W'(req_dir_x) <<< 16;
      ye    = VEC_W'(req_dir_y) <<< 16;
      zprod = req_dir_z * $signed({1'b0, GAIN_Q16});

      lane0_in.tag.valid = accept;
      lane0_in.tag.func  = req_func;
      lane0_in.tag.widx  = req_texel_index;
      lane0_in.tag.wdata = {req_red_in, req_green_in, req_blue_in};
      lane0_in.zero      = (req_dir_x == '0) && (req_dir_y == '0);
      lane0_in.zpos      = !req_dir_z[15] && (req_dir_z != '0);
      lane0_in.zneg      = req_dir_z[15];
      lane0_in.zb        = VEC_W'(zprod);
      lane0_in.lon       = '0;
      if (!req_dir_x[15] && (req_dir_x != '0)) begin
         lane0_in.a   = xe;
         lane0_in.b   = ye;
         lane0_in.ang = HALF_TURN;
      end else begin
         lane0_in.a   = -xe;
         lane0_in.b   = -ye;
         lane0_in.ang = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane0_ff.tag.valid <= 1'b0;
      end else begin
         lane0_ff <= lane0_in;
      end
   end

   assign chain[0] = lane0_ff;

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      eqrmap_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (STEP_W'(i % CORDIC_STEPS)),
         .load_lat (1'(i == CORDIC_STEPS)),
         .up_lane  (chain[i]),
         .dn_lane  (chain[i+1])
      );
   end

   eqrmap_coord u_coord (
      .clock      (clock),
      .reset      (reset),
      .map_width  (width_eff),
      .map_height (height_eff),
      .up_lane    (chain[NCELL]),
      .fetch      (fetch)
   );

   eqrmap_sample u_sample (
      .clock         (clock),
      .reset         (reset),
      .fetch         (fetch),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out)
   );

   `EQRMAP_ASSERT_IMPLY(top_rsp_from_lookup, rsp_valid, $past(accept && (req_func == FUNC_LOOKUP), RSP_DELAY), "result beat without a lookup beat")
   `EQRMAP_ASSERT_NEVER(top_accept_in_reset, accept && reset, "beat taken during reset")

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// Environment map lookup testbench
// Writes texels and looks up directions over several map shapes. Each colour
// is checked against a directed table value or a cycle-free predictor in this
// bench. Random lookups first fill any of their four neighbours still empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import eqrmap_pkg::*;

   typedef struct packed {
      logic               func;
      logic [16:0]        idx;
      logic [7:0]         r, g, b;
      logic signed [15:0] x, y, z;
      logic               chk;
      logic [15:0]        er, eg, eb;
   } beat_type;

   typedef struct packed {
      logic [15:0] r, g, b;
   } colour_type;

   localparam logic [31:0] ARC_STEP [16] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
      32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
      32'd166886, 32'd83443, 32'd41722, 32'd20861};

   localparam beat_type DIRECTED [16] = '{
      '{FUNC_WRITE, 17'd0, 8'hff, 8'h00, 8'ha5, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'h0, 16'h0, 16'h0},
      '{FUNC_WRITE, 17'd131071, 8'h5a, 8'hc3, 8'h01, -16'sd1, 16'sd0, 16'sd0, 1'b0,
         16'h0, 16'h0, 16'h0},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
         16'hff00, 16'h0000, 16'ha500},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, 16'sd0, 16'sd0, 16'sd32767, 1'b1,
         16'hff00, 16'h0000, 16'ha500},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, 16'sd0, 16'sd0, -16'sd32768, 1'b1,
         16'hff00, 16'h0000, 16'ha500},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1,
         16'hff00, 16'h0000, 16'ha500},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1,
         16'hff00, 16'h0000, 16'ha500},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, -16'sd32768, 16'sd0, 16'sd0, 1'b1,
         16'hff00, 16'h0000, 16'ha500},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, 16'sd32767, 16'sd0, 16'sd0, 1'b1,
         16'hff00, 16'h0000, 16'ha500},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, 16'sd0, -16'sd32768, 16'sd1, 1'b1,
         16'hff00, 16'h0000, 16'ha500},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, 16'sd0, 16'sd32767, -16'sd1, 1'b1,
         16'hff00, 16'h0000, 16'ha500},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, 16'sd1, -16'sd1, 16'sd0, 1'b1,
         16'hff00, 16'h0000, 16'ha500},
      '{FUNC_WRITE, 17'd0, 8'h00, 8'hff, 8'h00, 16'sd0, 16'sd0, 16'sd0, 1'b0,
         16'h0, 16'h0, 16'h0},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, 16'sd0, 16'sd0, 16'sd0, 1'b1,
         16'h0000, 16'hff00, 16'h0000},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, -16'sd5, 16'sd3, 16'sd9, 1'b0,
         16'h0, 16'h0, 16'h0},
      '{FUNC_LOOKUP, 17'd0, 8'h0, 8'h0, 8'h0, 16'sd0, 16'sd0, -16'sd1, 1'b0,
         16'h0, 16'h0, 16'h0}};

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic                        req_func;
   logic [ADDR_W-1:0]           req_texel_index;
   logic [7:0]                  req_red_in, req_green_in, req_blue_in;
   logic signed [15:0]          req_dir_x, req_dir_y, req_dir_z;
   logic                        rsp_valid;
   logic [COLOUR_W-1:0]         rsp_red_out, rsp_green_out, rsp_blue_out;
   logic                        csr_we;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_data;

   logic [23:0]  texels [MAX_TEXELS];
   bit           filled [MAX_TEXELS];
   int unsigned  map_w = 512;
   int unsigned  map_h = 256;
   colour_type   colour_q [$];
   int           errors = 0;
   int           beats = 0;
   int           checked = 0;
   int           shapes = 1;
   bit           no_gaps = 1'b0;

   equirect_env_map_bilinear_lookup_top dut (
      .clock, .reset, .start, .busy, .req_func, .req_texel_index,
      .req_red_in, .req_green_in, .req_blue_in, .req_dir_x, .req_dir_y, .req_dir_z,
      .rsp_valid, .rsp_red_out, .rsp_green_out, .rsp_blue_out,
      .csr_we, .csr_index, .csr_data);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   // vectoring rotation: angle of (a, b); a ends as the scaled magnitude
   function automatic logic [31:0] vector_angle(inout longint a, input longint b);
      logic [31:0] ang;
      longint      da, db;
      ang = '0;
      if (a < 0) begin
         a = -a;
         b = -b;
         ang = HALF_TURN;
      end
      for (int i = 0; i < 16; i++) begin
         da = b >>> i;
         db = a >>> i;
         if (b >= 0) begin
            a += da; b -= db; ang += ARC_STEP[i];
         end else begin
            a -= da; b += db; ang -= ARC_STEP[i];
         end
      end
      return ang;
   endfunction

   // texel indices of the four neighbours (c00, c01, c10, c11) and weights
   function automatic void map_taps(input logic signed [15:0] x, y, z,
                                    output int unsigned tap [4],
                                    output int unsigned sx, sy);
      longint            a, psi, v;
      logic [31:0]       u, lat;
      longint unsigned   xp, yp;
      int unsigned       w, h, col, row, col1, row1;
      w = (map_w == 0) ? 1 : map_w;
      h = (map_h == 0) ? 1 : map_h;
      if (x == 0 && y == 0) begin
         u = HALF_TURN;
         psi = (z > 0) ? longint'(QUARTER_TURN) : (z < 0 ? -longint'(QUARTER_TURN) : 0);
      end else begin
         a = -longint'(x) * 65536;
         u = vector_angle(a, -longint'(y) * 65536) + HALF_TURN;
         lat = vector_angle(a, longint'(z) * longint'(GAIN_Q16));
         psi = longint'($signed(lat));
      end
      v = longint'(QUARTER_TURN) - psi;
      if (v < 0) v = 0;
      if (v > longint'(HALF_TURN)) v = longint'(HALF_TURN);
      xp = (longint'(u) * w) >> 24;
      yp = (longint'(v) * h) >> 23;
      col = int'((xp >> 8) % w);
      row = int'((yp >> 8) % h);
      sx = int'(xp & 255);
      sy = int'(yp & 255);
      col1 = (col + 1) % w;
      row1 = (row + 1) % h;
      tap[0] = row * w + col;
      tap[1] = row1 * w + col;
      tap[2] = row * w + col1;
      tap[3] = row1 * w + col1;
   endfunction

   function automatic colour_type blend_colour(input logic signed [15:0] x, y, z);
      int unsigned     tap [4];
      int unsigned     sx, sy;
      logic [23:0]     c [4];
      longint unsigned p0, p1, p;
      logic [15:0]     ch [3];
      map_taps(x, y, z, tap, sx, sy);
      for (int k = 0; k < 4; k++)
         c[k] = (tap[k] < MAX_TEXELS) ? texels[tap[k]] : 24'h0;
      for (int n = 0; n < 3; n++) begin
         p0 = c[0][16-8*n +: 8] * (256 - sy) + c[1][16-8*n +: 8] * sy;
         p1 = c[2][16-8*n +: 8] * (256 - sy) + c[3][16-8*n +: 8] * sy;
         p = p0 * (256 - sx) + p1 * sx;
         ch[n] = 16'((p + 128) >> 8);
      end
      return '{ch[0], ch[1], ch[2]};
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic send_beat(input beat_type bt);
      int gap;
      start = 1'b1;
      req_func = bt.func;
      req_texel_index = bt.idx;
      req_red_in = bt.r;
      req_green_in = bt.g;
      req_blue_in = bt.b;
      req_dir_x = bt.x;
      req_dir_y = bt.y;
      req_dir_z = bt.z;
      do @(posedge clock); while (busy);
      beats++;
      if (bt.func == FUNC_WRITE) begin
         texels[bt.idx] = {bt.r, bt.g, bt.b};
         filled[bt.idx] = 1'b1;
      end else if (bt.chk)
         colour_q.push_back('{bt.er, bt.eg, bt.eb});
      else
         colour_q.push_back(blend_colour(bt.x, bt.y, bt.z));
      @(negedge clock);
      gap = gap_len();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] which, input int unsigned val);
      start = 1'b0;
      wait (colour_q.size() == 0);
      // writes in flight leave no trace at the output; let them land
      repeat (45) @(negedge clock);
      csr_we = 1'b1;
      csr_index = which;
      csr_data = CSR_DATA_W'(val);
      @(negedge clock);
      csr_we = 1'b0;
      if (which == CSR_MAP_WIDTH) map_w = val & 10'h3ff;
      else map_h = val & 9'h1ff;
   endtask

   function automatic beat_type random_beat(input logic func);
      beat_type bt;
      bt = '0;
      bt.func = func;
      bt.idx = 17'($urandom);
      bt.r = 8'($urandom);
      bt.g = 8'($urandom);
      bt.b = 8'($urandom);
      bt.x = 16'($urandom);
      bt.y = 16'($urandom);
      bt.z = 16'($urandom);
      bt.chk = 1'b0;
      case ($urandom_range(0, 5))
         0: begin
            bt.x = $urandom_range(0, 16) - 8;
            bt.y = $urandom_range(0, 16) - 8;
            bt.z = $urandom_range(0, 16) - 8;
         end
         1: bt.x = 0;
         2: begin
            bt.x = 0;
            bt.y = 0;
         end
         3: begin
            bt.x = (($urandom & 1) != 0) ? 16'sh7fff : 16'sh8000;
            bt.z = (($urandom & 1) != 0) ? 16'sh7fff : 16'sh8000;
         end
         4: bt.y = 0;
         default: ;
      endcase
      return bt;
   endfunction

   // fill any empty neighbour first, then look up
   task automatic probe(input beat_type bt);
      int unsigned tap [4];
      int unsigned sx, sy;
      beat_type    wr;
      map_taps(bt.x, bt.y, bt.z, tap, sx, sy);
      for (int k = 0; k < 4; k++)
         if (tap[k] < MAX_TEXELS && !filled[tap[k]]) begin
            wr = random_beat(FUNC_WRITE);
            wr.idx = tap[k];
            send_beat(wr);
         end
      send_beat(bt);
   endtask

   always @(posedge clock) begin
      colour_type e;
      if (!reset && rsp_valid) begin
         if (colour_q.size() == 0) begin
            $error("colour with none expected: %h %h %h",
                   rsp_red_out, rsp_green_out, rsp_blue_out);
            errors++;
         end else begin
            e = colour_q.pop_front();
            checked++;
            if (rsp_red_out !== e.r) begin
               $error("red_out expected %h got %h", e.r, rsp_red_out);
               errors++;
            end
            if (rsp_green_out !== e.g) begin
               $error("green_out expected %h got %h", e.g, rsp_green_out);
               errors++;
            end
            if (rsp_blue_out !== e.b) begin
               $error("blue_out expected %h got %h", e.b, rsp_blue_out);
               errors++;
            end
         end
      end
   end

   initial begin
      int unsigned shape_w [7] = '{512, 0, 1023, 7, 1, 512, 0};
      int unsigned shape_h [7] = '{256, 0, 511, 3, 256, 1, 0};
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_WRITE;
      req_texel_index = '0;
      req_red_in = '0;
      req_green_in = '0;
      req_blue_in = '0;
      req_dir_x = '0;
      req_dir_y = '0;
      req_dir_z = '0;
      csr_we = 1'b0;
      csr_index = CSR_MAP_WIDTH;
      csr_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // a 1 x 1 map: every lookup returns texel 0 exactly
      write_reg(CSR_MAP_WIDTH, 1);
      write_reg(CSR_MAP_HEIGHT, 1);
      foreach (DIRECTED[i]) send_beat(DIRECTED[i]);

      shape_w[6] = $urandom_range(1, 40);
      shape_h[6] = $urandom_range(1, 40);
      for (int s = 0; s < 7; s++) begin
         write_reg(CSR_MAP_WIDTH, shape_w[s]);
         write_reg(CSR_MAP_HEIGHT, shape_h[s]);
         shapes++;
         for (int n = 0; n < 90; n++) begin
            if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 3) send_beat(random_beat(FUNC_WRITE));
            else probe(random_beat(FUNC_LOOKUP));
         end
      end
      start = 1'b0;
      wait (colour_q.size() == 0);
      repeat (60) @(posedge clock);
      $display("run: %0d beats accepted, %0d colours checked", beats, checked);
      $display("run: %0d map shapes including zero and widest registers", shapes);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/eqrmap_pkg.sv
rtl/eqrmap_cell.sv
rtl/eqrmap_coord.sv
rtl/eqrmap_sample.sv
rtl/equirect_env_map_bilinear_lookup_top.sv
bench/testbench.sv
